[rtl/find_duplicate_by_swapping_defines.svh]
// assertion macros shared by the checker of the duplicate finder
// expects clk and rst in the scope of use, no other dependencies
`ifndef FIND_DUPLICATE_BY_SWAPPING_DEFINES_SVH
`define FIND_DUPLICATE_BY_SWAPPING_DEFINES_SVH

// same-cycle implication
`define FDBS_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fdbs: same-cycle check failed");

// next-cycle implication
`define FDBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fdbs: next-cycle check failed");

`endif

[rtl/fdbs_pkg.sv]
// types and constants of the duplicate finder
// no dependencies
package fdbs_pkg;

  localparam int MAX_ELEMENTS_DEF = 1024;
  localparam int ELEM_W           = 16;
  localparam int DUP_W            = 10;

  typedef enum logic [1:0] {
    STATUS_DUP   = 2'd0,
    STATUS_NONE  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_LOAD,
    S_CHK_RD,
    S_CHK_CMP,
    S_W_RD,
    S_W_LD,
    S_W_TEST,
    S_W_CMP,
    S_W_WR
  } state_e;

  typedef struct packed {
    logic signed [ELEM_W-1:0] element_value;
    logic                     last_element;
  } in_word_t;

  typedef struct packed {
    status_e          status;
    logic [DUP_W-1:0] dup_value;
  } out_word_t;

endpackage

[rtl/fdbs_store.sv]
// element store: one write port, one registered read port
// depends on fdbs_pkg for its default depth
module fdbs_store #(
  parameter int MAX_ELEMENTS = fdbs_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [$clog2(MAX_ELEMENTS)-1:0] waddr,
  input  logic [$clog2(MAX_ELEMENTS)-1:0] wdata,
  input  logic [$clog2(MAX_ELEMENTS)-1:0] raddr,
  output logic [$clog2(MAX_ELEMENTS)-1:0] rdata
);

  localparam int AW = $clog2(MAX_ELEMENTS);

  logic [AW-1:0] mem [MAX_ELEMENTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/fdbs_ctrl.sv]
// sequencer: loads words into the store, then runs range check and swap walk
// depends on fdbs_pkg, drives fdbs_store
module fdbs_ctrl #(
  parameter int MAX_ELEMENTS = fdbs_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  input  fdbs_pkg::in_word_t              item,
  output logic                            item_stall,
  output logic                            res_valid,
  output fdbs_pkg::out_word_t             res,
  input  logic                            res_take,
  output logic                            mem_we,
  output logic [$clog2(MAX_ELEMENTS)-1:0] mem_waddr,
  output logic [$clog2(MAX_ELEMENTS)-1:0] mem_wdata,
  output logic [$clog2(MAX_ELEMENTS)-1:0] mem_raddr,
  input  logic [$clog2(MAX_ELEMENTS)-1:0] mem_rdata
);

  import fdbs_pkg::*;

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int RW = ELEM_W + 1;

  state_e        state, state_next;
  logic [CW-1:0] count;
  logic          range_err;
  logic [CW-1:0] idx;
  logic [AW-1:0] cur;
  logic [AW-1:0] swap;
  logic          done;
  status_e       done_status;
  logic [AW-1:0] done_dup;

  logic [ELEM_W-1:0] raw;
  logic              accept;
  logic              bad;
  logic              full;
  logic              err_next;
  logic [CW-1:0]     idx_inc;
  logic              idx_last;
  logic              chk_bad;
  logic              fixed;
  logic              hit;

  assign raw      = item.element_value;
  assign accept   = item_valid && (state == S_LOAD) && !done;
  assign bad      = raw[ELEM_W-1] || (RW'(raw) >= RW'(MAX_ELEMENTS));
  assign full     = (count == CW'(MAX_ELEMENTS));
  assign err_next = range_err || bad || full;
  assign idx_inc  = CW'(idx + 1'b1);
  assign idx_last = (idx_inc == count);
  assign chk_bad  = (CW'(mem_rdata) >= count);
  assign fixed    = (cur == idx[AW-1:0]);
  assign hit      = (mem_rdata == cur);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD: begin
        if (accept && item.last_element && !err_next) begin
          state_next = S_CHK_RD;
        end
      end
      S_CHK_RD: state_next = S_CHK_CMP;
      S_CHK_CMP: begin
        if (chk_bad) begin
          state_next = S_LOAD;
        end else if (idx_last) begin
          state_next = S_W_RD;
        end
      end
      S_W_RD: state_next = S_W_LD;
      S_W_LD: state_next = S_W_TEST;
      S_W_TEST: begin
        if (fixed) begin
          state_next = idx_last ? S_LOAD : S_W_LD;
        end else begin
          state_next = S_W_CMP;
        end
      end
      S_W_CMP: state_next = hit ? S_LOAD : S_W_WR;
      S_W_WR: state_next = S_W_TEST;
      default: state_next = S_LOAD;
    endcase
  end

  // outputs and store access
  always_comb begin
    item_stall = (state != S_LOAD) || done;
    mem_we     = 1'b0;
    mem_waddr  = idx[AW-1:0];
    mem_wdata  = mem_rdata;
    mem_raddr  = idx[AW-1:0];
    unique case (state)
      S_LOAD: begin
        mem_we    = accept && !bad && !full;
        mem_waddr = count[AW-1:0];
        mem_wdata = raw[AW-1:0];
      end
      S_CHK_RD: mem_raddr = idx[AW-1:0];
      S_CHK_CMP: mem_raddr = idx_inc[AW-1:0];
      S_W_RD: mem_raddr = idx[AW-1:0];
      S_W_LD: mem_raddr = idx[AW-1:0];
      S_W_TEST: mem_raddr = fixed ? idx_inc[AW-1:0] : cur;
      S_W_CMP: begin
        mem_we    = !hit;
        mem_waddr = idx[AW-1:0];
        mem_wdata = mem_rdata;
      end
      S_W_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cur;
        mem_wdata = cur;
      end
      default: mem_raddr = idx[AW-1:0];
    endcase
    res_valid     = done;
    res.status    = done_status;
    res.dup_value = DUP_W'(done_dup);
  end

  function automatic logic [CW-1:0] idx_inc_load(input logic [CW-1:0] c);
    idx_inc_load = CW'(c + 1'b1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      range_err <= 1'b0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      if (done && res_take) begin
        done      <= 1'b0;
        count     <= '0;
        range_err <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            if (!full) begin
              count <= idx_inc_load(count);
            end
            range_err <= err_next;
            if (item.last_element && err_next) begin
              done <= 1'b1;
            end
          end
        end
        S_CHK_CMP: if (chk_bad) done <= 1'b1;
        S_W_TEST: if (fixed && idx_last) done <= 1'b1;
        S_W_CMP: if (hit) done <= 1'b1;
        default: ;
      endcase
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_LOAD: begin
        // keep a pending verdict until the output register takes it
        if (!done) begin
          idx         <= '0;
          done_status <= STATUS_RANGE;
          done_dup    <= '0;
        end
      end
      S_CHK_CMP: begin
        if (chk_bad) begin
          done_status <= STATUS_RANGE;
        end else if (idx_last) begin
          idx <= '0;
        end else begin
          idx <= idx_inc;
        end
      end
      S_W_LD: cur <= mem_rdata;
      S_W_TEST: begin
        if (fixed) begin
          idx         <= idx_inc;
          done_status <= STATUS_NONE;
        end
      end
      S_W_CMP: begin
        if (hit) begin
          done_status <= STATUS_DUP;
          done_dup    <= cur;
        end else begin
          swap <= mem_rdata;
        end
      end
      S_W_WR: cur <= swap;
      default: ;
    endcase
  end

endmodule

[rtl/find_duplicate_by_swapping.sv]
// duplicate finder: loads one word per cycle, a rate the store write port sets
// after the last word: range check over the stored words, then the swap walk, which loads
// each position and swaps it until fixed, then the verdict goes to the result register
// next array is taken once the result is in the output register
// sync reset returns to loading with empty count; the store needs no clearing
module find_duplicate_by_swapping #(
  parameter int MAX_ELEMENTS = fdbs_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  fdbs_pkg::in_word_t  item,
  output logic                result_valid,
  input  logic                result_stall,
  output fdbs_pkg::out_word_t result
);

  import fdbs_pkg::*;

  localparam int AW = $clog2(MAX_ELEMENTS);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [AW-1:0] mem_rdata;
  logic          res_valid;
  out_word_t     res;
  logic          res_take;

  fdbs_ctrl #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_stall (item_stall),
    .res_valid  (res_valid),
    .res        (res),
    .res_take   (res_take),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  fdbs_store #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register frees the sequencer while the word waits
  assign res_take = res_valid && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      result <= res;
    end
  end

endmodule

[rtl/fdbs_checker.sv]
// port-level checks of the duplicate finder, bound to the top level
// depends on fdbs_pkg and find_duplicate_by_swapping_defines.svh
`include "find_duplicate_by_swapping_defines.svh"

module fdbs_checker (
  input logic                clk,
  input logic                rst,
  input logic                item_valid,
  input logic                item_stall,
  input fdbs_pkg::in_word_t  item,
  input logic                result_valid,
  input logic                result_stall,
  input fdbs_pkg::out_word_t result
);

  import fdbs_pkg::*;

  // stalled result word holds
  `FDBS_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))

  // dup_value is zero unless a duplicate is reported
  `FDBS_ASSERT_IMPLY(a_dup_zero, result_valid && result.status != STATUS_DUP, result.dup_value == '0)

  // no result can appear right after a word is taken
  `FDBS_ASSERT_NEXT(a_no_early_result, item_valid && !item_stall, !$rose(result_valid))

  // closing word stops intake while the array is processed
  `FDBS_ASSERT_NEXT(a_stall_after_last, item_valid && !item_stall && item.last_element, item_stall)

endmodule

bind find_duplicate_by_swapping fdbs_checker u_fdbs_checker (.*);

[verif/find_duplicate_by_swapping_tb.sv]
// testbench of find_duplicate_by_swapping: arrays of words in, one verdict per array out
// keeps its own copy of the cyclic-swap scan and checks every verdict field by field
// depends on fdbs_pkg and the find_duplicate_by_swapping module
`timescale 1ns / 100ps

module find_duplicate_by_swapping_tb;
  import fdbs_pkg::*;

  localparam int STORE_DEPTH = MAX_ELEMENTS_DEF;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_stall;
  in_word_t  item = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  out_word_t result;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;

  // copy of the element store and load state
  logic [DUP_W-1:0] elem_copy [STORE_DEPTH];
  int               elem_count = 0;
  bit               elem_bad = 1'b0;
  out_word_t        array_verdict_q [$];

  find_duplicate_by_swapping u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // loads one word; the closing word of an array yields the expected verdict
  function automatic void scan_for_duplicate(input in_word_t w);
    logic [ELEM_W-1:0] raw;
    out_word_t         verdict;
    int                i;
    int                v;
    bit                done;
    raw = w.element_value;
    if (raw[ELEM_W-1] || raw >= ELEM_W'(STORE_DEPTH)) begin
      elem_bad = 1'b1;
      if (elem_count < STORE_DEPTH) elem_count++;
    end else if (elem_count < STORE_DEPTH) begin
      elem_copy[elem_count] = raw[DUP_W-1:0];
      elem_count++;
    end else begin
      elem_bad = 1'b1;
    end
    if (w.last_element) begin
      verdict.dup_value = '0;
      verdict.status = elem_bad ? STATUS_RANGE : STATUS_NONE;
      if (verdict.status == STATUS_NONE) begin
        for (i = 0; i < elem_count; i++) begin
          if (elem_copy[i] >= elem_count) verdict.status = STATUS_RANGE;
        end
      end
      if (verdict.status == STATUS_NONE) begin
        i = 0;
        done = 1'b0;
        while (i < elem_count && !done) begin
          if (elem_copy[i] == i) begin
            i++;
          end else begin
            v = elem_copy[i];
            if (elem_copy[v] == v) begin
              verdict.status = STATUS_DUP;
              verdict.dup_value = DUP_W'(v);
              done = 1'b1;
            end else begin
              elem_copy[i] = elem_copy[v];
              elem_copy[v] = DUP_W'(v);
            end
          end
        end
      end
      array_verdict_q.push_back(verdict);
      elem_count = 0;
      elem_bad = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && !result_stall) begin
      if (array_verdict_q.size() == 0) begin
        $error("result word with no verdict pending: status %0d dup_value %0d",
               result.status, result.dup_value);
        mismatch_count++;
      end else begin
        if (result.status !== array_verdict_q[0].status) begin
          $error("status: expected %0d, actual %0d", array_verdict_q[0].status, result.status);
          mismatch_count++;
        end
        if (result.dup_value !== array_verdict_q[0].dup_value) begin
          $error("dup_value: expected %0d, actual %0d",
                 array_verdict_q[0].dup_value, result.dup_value);
          mismatch_count++;
        end
        void'(array_verdict_q.pop_front());
      end
    end
  end

  // valid is left high after acceptance; the next call lowers it only when it idles
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= w;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    scan_for_duplicate(w);
  endtask

  task automatic send_array(input int vals[$]);
    in_word_t w;
    int       k;
    for (k = 0; k < vals.size(); k++) begin
      w.element_value = ELEM_W'(vals[k]);
      w.last_element = (k == vals.size() - 1);
      send_word(w);
    end
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    do @(posedge clk); while (array_verdict_q.size() != 0);
  endtask

  function automatic void shuffle(ref int arr[$]);
    int k;
    int j;
    int tmp;
    for (k = arr.size() - 1; k > 0; k--) begin
      j = $urandom_range(k, 0);
      tmp = arr[k];
      arr[k] = arr[j];
      arr[j] = tmp;
    end
  endfunction

  task automatic test_directed();
    send_array('{0});
    send_array('{1});
    send_array('{0, 0});
    send_array('{1, 0});
    send_array('{1, 1});
    send_array('{-1, 0});
    send_array('{-32768, 1});
    send_array('{32767, 0});
    send_array('{1024, 0});
    send_array('{1023, 0});
    send_array('{2, 0, 1});
    send_array('{2, 2, 0});
  endtask

  // fills the whole store and runs one word past it
  task automatic test_capacity();
    int arr[$];
    int k;
    for (k = 0; k < STORE_DEPTH; k++) arr.push_back(k);
    shuffle(arr);
    arr.push_back($urandom_range(STORE_DEPTH - 1, 0));
    send_array(arr);
  endtask

  task automatic test_random(input int n_words);
    int arr[$];
    int sent;
    int n;
    int k;
    int kind;
    int dups;
    sent = 0;
    while (sent < n_words) begin
      arr.delete();
      n = ($urandom_range(99) < 5) ? $urandom_range(200, 17) : $urandom_range(16, 1);
      for (k = 0; k < n; k++) arr.push_back(k);
      shuffle(arr);
      kind = $urandom_range(99);
      if (kind < 55 && n > 1) begin
        // one or more duplicates over a permutation
        dups = (kind < 40) ? 1 : $urandom_range(4, 2);
        for (k = 0; k < dups; k++) arr[$urandom_range(n - 1, 0)] = arr[$urandom_range(n - 1, 0)];
      end else if (kind < 75) begin
        // clean permutation
      end else if (kind < 85) begin
        arr[$urandom_range(n - 1, 0)] = $urandom_range(STORE_DEPTH - 1, n);
      end else if (kind < 92) begin
        arr[$urandom_range(n - 1, 0)] = int'($signed(ELEM_W'($urandom) | 16'h8000));
      end else begin
        arr[$urandom_range(n - 1, 0)] = int'($signed(ELEM_W'($urandom)));
      end
      send_array(arr);
      sent += n;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 34;
    recv_stall_pct = 62;
    test_directed();
    test_capacity();
    test_random(30);
    wait_drained();

    send_idle_pct = 62;
    recv_stall_pct = 34;
    test_random(30);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(25);
    test_directed();

    wait_drained();
    repeat (64) @(posedge clk);
    if (array_verdict_q.size() != 0) begin
      $error("%0d verdicts never arrived", array_verdict_q.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
